// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants and types of the timer write-status tracker: register
// offsets, state widths and the decoded access descriptor.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned NUM_LOCAL_TIMERS = 4;
  localparam int unsigned LocIdxW = (NUM_LOCAL_TIMERS > 1) ? $clog2(NUM_LOCAL_TIMERS) : 1;

  localparam int unsigned OffW     = 12;
  localparam int unsigned DataW    = 32;
  localparam int unsigned TimerW   = 4;
  localparam int unsigned CountW   = 2;
  localparam int unsigned CompareW = 17;
  localparam int unsigned LocalW   = 4;

  // Global region
  localparam logic [OffW-1:0] CountBase     = 12'h100;
  localparam logic [OffW-1:0] CountStatus   = 12'h110;
  localparam logic [OffW-1:0] CompareBase   = 12'h200;
  localparam logic [OffW-1:0] CompareEnd    = 12'h244;
  localparam logic [OffW-1:0] CompareStatus = 12'h24C;
  localparam logic [OffW-1:0] LocalBase     = 12'h300;

  // Local window offsets
  localparam logic [7:0] LocCompareLo = 8'h00;
  localparam logic [7:0] LocCompareHi = 8'h08;
  localparam logic [7:0] LocControl   = 8'h20;
  localparam logic [7:0] LocIntEnable = 8'h34;
  localparam logic [7:0] LocStatus    = 8'h40;

  // Local status bits
  localparam int unsigned LocCompareBit = 1;
  localparam int unsigned LocControlBit = 3;

  typedef struct packed {
    logic                cnt_set;
    logic                cnt_idx;
    logic                cnt_clr;
    logic                cnt_rd;
    logic                cmp_set;
    logic [4:0]          cmp_idx;
    logic                cmp_clr;
    logic                cmp_rd;
    logic [LocIdxW-1:0]  loc_idx;
    logic                loc_set_cmp;
    logic                loc_set_ctl;
    logic                loc_clr;
    logic                loc_rd;
    logic                unknown;
  } access_t;

endpackage

// ===== rtl/tws_decode.sv =====
// ----------------------------------------------------------------------------
// tws_decode
// Offset decoder: turns one bus access into set/clear/read strobes.
// ----------------------------------------------------------------------------
module tws_decode (
  input  logic                          action_i,
  input  logic [tws_pkg::OffW-1:0]      offset_i,
  output tws_pkg::access_t              access_o
);

  logic                       global_hit;
  logic [tws_pkg::TimerW-1:0] timer;
  logic [7:0]                 loff;
  logic                       timer_hit;

  always_comb begin
    global_hit = offset_i < tws_pkg::LocalBase;
    timer      = offset_i[11:8] - tws_pkg::LocalBase[11:8];
    // local base is 256-aligned, so the local offset is the low byte
    loff       = offset_i[7:0];
    timer_hit  = timer < tws_pkg::TimerW'(tws_pkg::NUM_LOCAL_TIMERS);

    access_o         = '0;
    access_o.cnt_idx = offset_i[2];
    access_o.cmp_idx = offset_i[6:2];
    access_o.loc_idx = timer[tws_pkg::LocIdxW-1:0];

    if (global_hit) begin
      if (action_i) begin
        if (offset_i[11:3] == tws_pkg::CountBase[11:3]) begin
          access_o.cnt_set = 1'b1;
        end else if (offset_i == tws_pkg::CountStatus) begin
          access_o.cnt_clr = 1'b1;
        end else if (offset_i >= tws_pkg::CompareBase && offset_i < tws_pkg::CompareEnd) begin
          access_o.cmp_set = 1'b1;
        end else if (offset_i == tws_pkg::CompareStatus) begin
          access_o.cmp_clr = 1'b1;
        end else begin
          access_o.unknown = 1'b1;
        end
      end else begin
        access_o.cnt_rd = offset_i == tws_pkg::CountStatus;
        access_o.cmp_rd = offset_i == tws_pkg::CompareStatus;
      end
    end else if (!timer_hit) begin
      // drop accesses to timers that do not exist
      access_o.unknown = action_i;
    end else if (!action_i) begin
      access_o.loc_rd = loff == tws_pkg::LocStatus;
    end else begin
      if (loff inside {tws_pkg::LocCompareLo, tws_pkg::LocCompareHi}) begin
        access_o.loc_set_cmp = 1'b1;
      end else if (loff == tws_pkg::LocControl) begin
        access_o.loc_set_ctl = 1'b1;
      end else if (loff == tws_pkg::LocIntEnable) begin
        access_o.unknown = 1'b0;
      end else if (loff == tws_pkg::LocStatus) begin
        access_o.loc_clr = 1'b1;
      end else begin
        access_o.unknown = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tws_status.sv =====
// ----------------------------------------------------------------------------
// tws_status
// Status registers: global count/compare status and per-timer local status,
// with set, masked clear and read-back.
// ----------------------------------------------------------------------------
module tws_status (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  tws_pkg::access_t            access_i,
  input  logic [tws_pkg::DataW-1:0]   clr_i,
  output logic [tws_pkg::DataW-1:0]   read_data_o
);

  logic [tws_pkg::CountW-1:0]   count_q, count_d;
  logic [tws_pkg::CompareW-1:0] compare_q, compare_d;
  logic [tws_pkg::LocalW-1:0]   local_q [tws_pkg::NUM_LOCAL_TIMERS];
  logic [tws_pkg::LocalW-1:0]   local_d [tws_pkg::NUM_LOCAL_TIMERS];

  always_comb begin
    count_d   = count_q;
    compare_d = compare_q;
    local_d   = local_q;
    if (access_i.cnt_set) begin
      count_d[access_i.cnt_idx] = 1'b1;
    end
    if (access_i.cnt_clr) begin
      count_d = count_q & ~clr_i[tws_pkg::CountW-1:0];
    end
    if (access_i.cmp_set) begin
      compare_d[access_i.cmp_idx] = 1'b1;
    end
    if (access_i.cmp_clr) begin
      compare_d = compare_q & ~clr_i[tws_pkg::CompareW-1:0];
    end
    if (access_i.loc_set_cmp) begin
      local_d[access_i.loc_idx][tws_pkg::LocCompareBit] = 1'b1;
    end
    if (access_i.loc_set_ctl) begin
      local_d[access_i.loc_idx][tws_pkg::LocControlBit] = 1'b1;
    end
    if (access_i.loc_clr) begin
      local_d[access_i.loc_idx] = local_q[access_i.loc_idx] & ~clr_i[tws_pkg::LocalW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      compare_q <= '0;
      for (int i = 0; i < tws_pkg::NUM_LOCAL_TIMERS; i++) begin
        local_q[i] <= '0;
      end
    end else if (en_i) begin
      count_q   <= count_d;
      compare_q <= compare_d;
      local_q   <= local_d;
    end
  end

  always_comb begin
    read_data_o = '0;
    if (access_i.cnt_rd) begin
      read_data_o = tws_pkg::DataW'(count_q);
    end else if (access_i.cmp_rd) begin
      read_data_o = tws_pkg::DataW'(compare_q);
    end else if (access_i.loc_rd) begin
      read_data_o = tws_pkg::DataW'(local_q[access_i.loc_idx]);
    end
  end

endmodule

// ===== rtl/timer_write_status_tracker_top.sv =====
// ----------------------------------------------------------------------------
// timer_write_status_tracker_top
// Write-status tracker for a multi-core timer register window.
// ----------------------------------------------------------------------------
// One bus access per item, one result item per access. An item sits in an
// input register, is decoded and applied to the status registers, and its
// read data lands in an output register. The result is valid once the item
// has moved on from the input register into the output register, which can
// wait while the output side stalls. With the output side ready an item is
// taken every cycle, since decode and status update fit in one stage and
// the output register frees the input side while a result waits.
module timer_write_status_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [tws_pkg::OffW-1:0]           offset_i,
  input  logic [tws_pkg::DataW-1:0]          write_data_i,
  input  logic [tws_pkg::DataW-1:0]          write_mask_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tws_pkg::DataW-1:0]          read_data_o,
  output logic                               unknown_offset_o
);

  logic                        in_valid_q;
  logic                        action_q;
  logic [tws_pkg::OffW-1:0]    offset_q;
  logic [tws_pkg::DataW-1:0]   clr_q;
  logic                        out_valid_q;
  logic [tws_pkg::DataW-1:0]   read_data_q, read_data_d;
  logic                        unknown_q;
  logic                        advance;
  tws_pkg::access_t            access;
  tws_pkg::access_t            access_en;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      offset_q <= offset_i;
      clr_q    <= write_data_i & write_mask_i;
    end
    if (advance) begin
      read_data_q <= read_data_d;
      unknown_q   <= access.unknown;
    end
  end

  tws_decode u_decode (
    .action_i (action_q),
    .offset_i (offset_q),
    .access_o (access)
  );

  // gate the strobes so a held item updates status only once
  always_comb begin
    access_en = access;
    if (!advance) begin
      access_en.cnt_set     = 1'b0;
      access_en.cnt_clr     = 1'b0;
      access_en.cmp_set     = 1'b0;
      access_en.cmp_clr     = 1'b0;
      access_en.loc_set_cmp = 1'b0;
      access_en.loc_set_ctl = 1'b0;
      access_en.loc_clr     = 1'b0;
    end
  end

  tws_status u_status (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .access_i    (access_en),
    .clr_i       (clr_q),
    .read_data_o (read_data_d)
  );

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = read_data_q;
  assign unknown_offset_o = unknown_q;

  // Nonzero read data only comes from reads, which never flag an unknown offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_data_o != '0) |-> !unknown_offset_o)
    else $error("read data and unknown offset both set");

  // Status words are at most 17 bits wide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_data_o[31:17] == '0))
    else $error("read data upper bits set");

  // An empty output register never stalls the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  // A pending item reaches the output in the next cycle when the output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("item did not advance to output");

endmodule

// ===== tb/sv/timer_write_status_tracker_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_write_status_tracker_top_tb
// Self-checking bench for the timer write-status tracker. A short table of
// register accesses covers the decode corners: count, compare and local
// status set and clear, unmapped writes, and timers past the last one. It is
// followed by random accesses biased toward mapped offsets. A behavioral copy
// of the status words predicts each untyped response. Both handshake sides
// idle at random; one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module timer_write_status_tracker_top_tb;
  import tws_pkg::*;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [OffW-1:0] CountEnd     = CountBase + 12'h008;
  localparam int unsigned     MaxTimerSlot = 12;

  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HOLD_AT      = 1000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             unknown;
  } status_result_t;

  typedef struct {
    logic             act;
    logic [OffW-1:0]  off;
    logic [DataW-1:0] data;
    logic [DataW-1:0] mask;
    bit               typed;
    logic [DataW-1:0] rd;
    logic             unk;
  } access_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             action_i;
  logic [OffW-1:0]  offset_i;
  logic [DataW-1:0] write_data_i;
  logic [DataW-1:0] write_mask_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [DataW-1:0] read_data_o;
  logic             unknown_offset_o;

  // predicted status words
  logic [CountW-1:0]   count_st;
  logic [CompareW-1:0] compare_st;
  logic [LocalW-1:0]   local_st [NUM_LOCAL_TIMERS];

  status_result_t pending_responses [$];
  int unsigned    mismatch_cnt = 0;
  int unsigned    accepted_cnt = 0;
  int unsigned    cycle_cnt    = 0;
  int unsigned    idle_pct     = IDLE_PCT;

  access_row_t directed_rows [26] = '{
    '{ACT_READ,  CountStatus,            32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  CompareStatus,          32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  LocalBase + 12'h040,    32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, CountBase,              '1,    '1,    1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, CountBase + 12'h007,    32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  CountStatus,            32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ACT_WRITE, CompareBase,            32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, CompareEnd - 12'h001,   '1,    32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  CompareStatus,          32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ACT_WRITE, CompareStatus,          '1,    '1,    1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, CountStatus,            '1,    32'h1, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  CountStatus,            32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ACT_WRITE, CountEnd,               32'h0, 32'h0, 1'b1, 32'h0, 1'b1},
    '{ACT_WRITE, 12'h000,                32'h0, 32'h0, 1'b1, 32'h0, 1'b1},
    '{ACT_WRITE, CompareEnd,             32'h0, 32'h0, 1'b1, 32'h0, 1'b1},
    '{ACT_WRITE, LocalBase,              32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, LocalBase + 12'h108,    32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, LocalBase + 12'h220,    32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, LocalBase + 12'h334,    '1,    '1,    1'b1, 32'h0, 1'b0},
    '{ACT_WRITE, LocalBase + 12'h33C,    32'h0, 32'h0, 1'b1, 32'h0, 1'b1},
    '{ACT_WRITE, LocalBase + 12'h240,    32'hFFFF_FFF7, '1, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  LocalBase + 12'h240,    32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ACT_WRITE, LocalBase + 12'h400,    32'h0, 32'h0, 1'b1, 32'h0, 1'b1},
    '{ACT_WRITE, 12'hFFF,                '1,    '1,    1'b1, 32'h0, 1'b1},
    '{ACT_READ,  12'hFFF,                32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{ACT_READ,  LocalBase + 12'h040,    32'h0, 32'h0, 1'b0, 32'h0, 1'b0}
  };

  timer_write_status_tracker_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .offset_i         (offset_i),
    .write_data_i     (write_data_i),
    .write_mask_i     (write_mask_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .unknown_offset_o (unknown_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one access to the predicted status words and return its response.
  function automatic status_result_t predict_status_access(
    input logic             act,
    input logic [OffW-1:0]  off,
    input logic [DataW-1:0] data,
    input logic [DataW-1:0] mask
  );
    status_result_t   res;
    logic [DataW-1:0] clr;
    logic [OffW-1:0]  rel;
    int unsigned      slot;
    logic [7:0]       loff;
    res = '0;
    clr = data & mask;
    if (off < LocalBase) begin
      if (act == ACT_READ) begin
        if (off == CountStatus) res.read_data = DataW'(count_st);
        else if (off == CompareStatus) res.read_data = DataW'(compare_st);
      end else if (off >= CountBase && off < CountEnd) begin
        count_st[(off - CountBase) >> 2] = 1'b1;
      end else if (off == CountStatus) begin
        count_st &= ~clr[CountW-1:0];
      end else if (off >= CompareBase && off < CompareEnd) begin
        compare_st[(off - CompareBase) >> 2] = 1'b1;
      end else if (off == CompareStatus) begin
        compare_st &= ~clr[CompareW-1:0];
      end else begin
        res.unknown = 1'b1;
      end
    end else begin
      rel  = off - LocalBase;
      slot = rel >> 8;
      loff = rel[7:0];
      if (slot >= NUM_LOCAL_TIMERS) begin
        res.unknown = (act == ACT_WRITE);
      end else if (act == ACT_READ) begin
        if (loff == LocStatus) res.read_data = DataW'(local_st[slot]);
      end else if (loff == LocCompareLo || loff == LocCompareHi) begin
        local_st[slot][LocCompareBit] = 1'b1;
      end else if (loff == LocControl) begin
        local_st[slot][LocControlBit] = 1'b1;
      end else if (loff == LocStatus) begin
        local_st[slot] &= ~clr[LocalW-1:0];
      end else if (loff != LocIntEnable) begin
        res.unknown = 1'b1;
      end
    end
    return res;
  endfunction

  // Bias toward mapped registers; a fifth of the offsets are fully random.
  function automatic logic [OffW-1:0] pick_offset();
    int unsigned sel;
    int unsigned slot;
    logic [7:0]  loff;
    sel = $urandom_range(99);
    if (sel < 10) return CountBase + OffW'($urandom_range(7));
    if (sel < 20) return CountStatus;
    if (sel < 35) return CompareBase + OffW'($urandom_range(16) * 4 + $urandom_range(3));
    if (sel < 45) return CompareStatus;
    if (sel < 80) begin
      slot = ($urandom_range(99) < 80) ? $urandom_range(NUM_LOCAL_TIMERS - 1)
                                       : $urandom_range(MaxTimerSlot);
      case ($urandom_range(5))
        0:       loff = LocCompareLo;
        1:       loff = LocCompareHi;
        2:       loff = LocControl;
        3:       loff = LocIntEnable;
        4:       loff = LocStatus;
        default: loff = 8'($urandom_range(255));
      endcase
      return LocalBase + OffW'(slot << 8) + OffW'(loff);
    end
    return OffW'($urandom_range(4095));
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return DataW'($urandom);
  endfunction

  // Hold the item until taken, then record its predicted response.
  task automatic issue_access(
    input logic             act,
    input logic [OffW-1:0]  off,
    input logic [DataW-1:0] data,
    input logic [DataW-1:0] mask,
    input bit               typed,
    input status_result_t   typed_res
  );
    status_result_t model_res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    offset_i     <= off;
    write_data_i <= data;
    write_mask_i <= mask;
    do @(posedge clk_i); while (!in_ready_o);
    model_res = predict_status_access(act, off, data, mask);
    pending_responses.push_back(typed ? typed_res : model_res);
    accepted_cnt++;
  endtask

  initial begin : drive_accesses
    logic act;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_READ;
    offset_i     <= '0;
    write_data_i <= '0;
    write_mask_i <= '0;
    count_st   = '0;
    compare_st = '0;
    for (int t = 0; t < NUM_LOCAL_TIMERS; t++) local_st[t] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      issue_access(directed_rows[r].act, directed_rows[r].off, directed_rows[r].data,
                   directed_rows[r].mask, directed_rows[r].typed,
                   status_result_t'({directed_rows[r].rd, directed_rows[r].unk}));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // leave a long back-to-back stretch in the middle
      idle_pct = (n >= 300 && n < 600) ? 0 : IDLE_PCT;
      act = ($urandom_range(99) < 40) ? ACT_READ : ACT_WRITE;
      issue_access(act, pick_offset(), pick_word(), pick_word(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_responses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : accept_responses
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!held && accepted_cnt >= HOLD_AT) begin
        // back up the pipe while the sender keeps offering items
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (accepted_cnt >= 450 && accepted_cnt < 750) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    status_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected response: read_data=%h unknown_offset=%b",
                   read_data_o, unknown_offset_o);
      end else begin
        want = pending_responses.pop_front();
        if (read_data_o !== want.read_data || unknown_offset_o !== want.unknown) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: read_data exp %h got %h, unknown_offset exp %b got %b",
                     want.read_data, read_data_o, want.unknown, unknown_offset_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, pending_responses.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
